// ===== design/e2q_pkg.sv =====
// shared constants, types and tables for the euler to quaternion converter
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ANGLE_W = 16;
    localparam int QW = 16;
    localparam int CW = 33;   // cordic x/y/z width, q30 plus sign and headroom
    localparam int TW = 18;   // q16 trig value width
    localparam logic signed [ANGLE_W:0] HALF_QUARTER = 17'sd11520;
    localparam logic signed [ANGLE_W:0] HALF_HALFTURN = 17'sd23040;
    localparam logic signed [18:0] RAD_SCALE = 19'sd146409;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [QW-1:0] OUT_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic neg;
    } cordic_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0: r = 33'sd843314856;  5'd1: r = 33'sd497837829;
            5'd2: r = 33'sd263043836;  5'd3: r = 33'sd133525158;
            5'd4: r = 33'sd67021686;   5'd5: r = 33'sd33543515;
            5'd6: r = 33'sd16775850;   5'd7: r = 33'sd8388437;
            5'd8: r = 33'sd4194282;    5'd9: r = 33'sd2097149;
            5'd10: r = 33'sd1048575;   5'd11: r = 33'sd524287;
            5'd12: r = 33'sd262143;    5'd13: r = 33'sd131071;
            5'd14: r = 33'sd65535;     5'd15: r = 33'sd32767;
            5'd16: r = 33'sd16383;     5'd17: r = 33'sd8191;
            5'd18: r = 33'sd4095;      5'd19: r = 33'sd2047;
            5'd20: r = 33'sd1023;      5'd21: r = 33'sd511;
            5'd22: r = 33'sd255;       5'd23: r = 33'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// ===== design/e2q_cordic_cell.sv =====
// one rotation stage of the cordic chain
`timescale 1ns / 1ps
module e2q_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic aclk,
    input  logic en,
    input  e2q_pkg::cordic_t d_in,
    output e2q_pkg::cordic_t d_out
);
    e2q_pkg::cordic_t q_reg, q_next;
    logic signed [e2q_pkg::CW-1:0] dx, dy, at;

    always_comb begin
        dx = d_in.y >>> STAGE;
        dy = d_in.x >>> STAGE;
        at = e2q_pkg::atan_q30(5'(STAGE));
        q_next.neg = d_in.neg;
        if (!d_in.z[e2q_pkg::CW-1]) begin
            q_next.x = d_in.x - dx;
            q_next.y = d_in.y + dy;
            q_next.z = d_in.z - at;
        end else begin
            q_next.x = d_in.x + dx;
            q_next.y = d_in.y - dy;
            q_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) q_reg <= q_next;
    end
    assign d_out = q_reg;
endmodule

// ===== design/e2q_sincos.sv =====
// half-angle fold, radian scaling, cordic chain and q16 rounding
`timescale 1ns / 1ps
module e2q_sincos #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic aclk,
    input  logic en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
    output logic signed [e2q_pkg::TW-1:0] cos_q16,
    output logic signed [e2q_pkg::TW-1:0] sin_q16
);
    localparam int N = (TRIG_STAGES < e2q_pkg::ATAN_ENTRIES) ? TRIG_STAGES
                                                              : e2q_pkg::ATAN_ENTRIES;
    e2q_pkg::cordic_t chain [0:N];
    e2q_pkg::cordic_t init_reg, init_next;
    logic signed [e2q_pkg::ANGLE_W:0] a;
    logic signed [35:0] prod;
    logic signed [e2q_pkg::CW-1:0] xf, yf, xr, yr;
    logic signed [e2q_pkg::TW-1:0] c_reg, s_reg;

    always_comb begin
        a = {angle[e2q_pkg::ANGLE_W-1], angle};
        init_next.neg = 1'b0;
        if (a > e2q_pkg::HALF_QUARTER) begin
            a = a - e2q_pkg::HALF_HALFTURN;
            init_next.neg = 1'b1;
        end else if (a < -e2q_pkg::HALF_QUARTER) begin
            a = a + e2q_pkg::HALF_HALFTURN;
            init_next.neg = 1'b1;
        end
        prod = 36'(a) * 36'(e2q_pkg::RAD_SCALE);
        init_next.x = e2q_pkg::CORDIC_GAIN;
        init_next.y = '0;
        init_next.z = prod[e2q_pkg::CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) init_reg <= init_next;
    end
    assign chain[0] = init_reg;

    for (genvar g = 0; g < N; g++) begin : g_cell
        e2q_cordic_cell #(.STAGE(g)) u_cell (
            .aclk(aclk), .en(en), .d_in(chain[g]), .d_out(chain[g+1]));
    end

    always_comb begin
        xf = chain[N].neg ? -chain[N].x : chain[N].x;
        yf = chain[N].neg ? -chain[N].y : chain[N].y;
        xr = (xf + 33'sd8192) >>> 14;
        yr = (yf + 33'sd8192) >>> 14;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= xr[e2q_pkg::TW-1:0];
            s_reg <= yr[e2q_pkg::TW-1:0];
        end
    end
    assign cos_q16 = c_reg;
    assign sin_q16 = s_reg;
endmodule

// ===== design/e2q_combine.sv =====
// triple products and sums, rounded and saturated to q2.14
`timescale 1ns / 1ps
module e2q_combine (
    input  logic aclk,
    input  logic en,
    input  logic signed [e2q_pkg::TW-1:0] cp, sp, cy, sy, cr, sr,
    output logic signed [e2q_pkg::QW-1:0] qw, qx, qy, qz
);
    localparam int PW = 2 * e2q_pkg::TW;
    localparam int SW = 54;
    logic signed [PW-1:0] pc_reg, ps_reg, cs_reg, sc_reg;
    logic signed [e2q_pkg::TW-1:0] cr_reg, sr_reg;
    logic signed [SW-1:0] t_reg [0:7];
    logic signed [SW-1:0] s_reg [0:3];
    logic signed [e2q_pkg::QW-1:0] q_reg [0:3];
    logic signed [SW-1:0] r [0:3];
    logic signed [e2q_pkg::QW-1:0] q_next [0:3];

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg <= PW'(cp) * PW'(cy); ps_reg <= PW'(sp) * PW'(sy);
            sc_reg <= PW'(sp) * PW'(cy); cs_reg <= PW'(cp) * PW'(sy);
            cr_reg <= cr; sr_reg <= sr;
            t_reg[0] <= SW'(cr_reg) * SW'(pc_reg); t_reg[1] <= SW'(sr_reg) * SW'(ps_reg);
            t_reg[2] <= SW'(sr_reg) * SW'(pc_reg); t_reg[3] <= SW'(cr_reg) * SW'(ps_reg);
            t_reg[4] <= SW'(cr_reg) * SW'(sc_reg); t_reg[5] <= SW'(sr_reg) * SW'(cs_reg);
            t_reg[6] <= SW'(cr_reg) * SW'(cs_reg); t_reg[7] <= SW'(sr_reg) * SW'(sc_reg);
            s_reg[0] <= t_reg[0] + t_reg[1]; s_reg[1] <= t_reg[2] - t_reg[3];
            s_reg[2] <= t_reg[4] + t_reg[5]; s_reg[3] <= t_reg[6] - t_reg[7];
            for (int k = 0; k < 4; k++) q_reg[k] <= q_next[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            r[k] = (s_reg[k] + (SW'(1) <<< 33)) >>> 34;
            if (r[k] > SW'(e2q_pkg::OUT_ONE)) q_next[k] = e2q_pkg::OUT_ONE;
            else if (r[k] < -SW'(e2q_pkg::OUT_ONE)) q_next[k] = -e2q_pkg::OUT_ONE;
            else q_next[k] = r[k][e2q_pkg::QW-1:0];
        end
    end

    assign qw = q_reg[0];
    assign qx = q_reg[1];
    assign qy = q_reg[2];
    assign qz = q_reg[3];
endmodule

// ===== design/euler_to_quaternion.sv =====
// top level: euler angle triples in, unit quaternions out
// Takes one angle triple per cycle and returns one quaternion per triple.
// The pipeline has one fold and scale stage, one cordic cell per stage,
// one rounding stage, then four product, sum and saturate stages. The
// whole pipeline advances whenever the output register is empty or being
// drained, so throughput is one transfer per cycle.
`timescale 1ns / 1ps
module euler_to_quaternion #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [47:0] s_tdata,   // pitch_angle, yaw_angle, roll_angle
    output logic m_tvalid,
    input  logic m_tready,
    output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    localparam int N = (TRIG_STAGES < e2q_pkg::ATAN_ENTRIES) ? TRIG_STAGES
                                                              : e2q_pkg::ATAN_ENTRIES;
    localparam int LAT = N + 6;
    logic [LAT-1:0] vld_reg, vld_next;
    logic en;
    logic signed [e2q_pkg::TW-1:0] cp, sp, cy, sy, cr, sr;
    logic signed [e2q_pkg::QW-1:0] qw, qx, qy, qz;

    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_comb begin
        vld_next = vld_reg;
        if (en) vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else vld_reg <= vld_next;
    end

    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_tdata[15:0]), .cos_q16(cp), .sin_q16(sp));
    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_tdata[31:16]), .cos_q16(cy), .sin_q16(sy));
    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
        .aclk(aclk), .en(en), .angle(s_tdata[47:32]), .cos_q16(cr), .sin_q16(sr));

    e2q_combine u_comb (
        .aclk(aclk), .en(en), .cp(cp), .sp(sp), .cy(cy), .sy(sy), .cr(cr), .sr(sr),
        .qw(qw), .qx(qx), .qy(qy), .qz(qz));

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = {qz, qy, qx, qw};
endmodule

// ===== design/euler_to_quaternion_checker.sv =====
// port-level checks for the euler to quaternion converter
`timescale 1ns / 1ps
module euler_to_quaternion_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [63:0] m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");
    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                     ($signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("quat_w out of range");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind euler_to_quaternion euler_to_quaternion_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
